FILE: rtl/pcm_credit_pacing_queue_macros.svh
// Assertion helpers shared by the credit pacing queue modules.
`ifndef PCM_CREDIT_PACING_QUEUE_MACROS_SVH
`define PCM_CREDIT_PACING_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pcq_pkg.sv
package pcq_pkg;

   localparam int RingBeatsDefault  = 32768;
   localparam int QueueDepthDefault = 16;

   localparam int FreeWidth = 15;
   localparam int PtrWidth  = 16;
   localparam int TotWidth  = 32;

   // Register indexes of the configuration channel
   localparam logic CSR_DRAIN_ENABLE = 1'b0;
   localparam logic CSR_NEED_BEATS   = 1'b1;

   typedef enum logic [1:0] {
      KIND_CONSUME = 2'd0,
      KIND_FRAME   = 2'd1,
      KIND_DRAIN   = 2'd2,
      KIND_REBASE  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CONSUME,
      OP_FRAME_NEW,
      OP_RD_LAST,
      OP_FRAME_MERGE,
      OP_DRAIN_START,
      OP_RD_TAIL,
      OP_RETIRE,
      OP_FLUSH,
      OP_REBASE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MERGE,
      ST_CHECK,
      ST_STEP,
      ST_FLUSH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      op_type op;
      logic   load_item;
      logic   load_rsp;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     q_empty;
      logic     q_full;
      logic     can_retire;
   } status_type;

   typedef struct packed {
      logic [TotWidth-1:0] bytes;
      logic [PtrWidth-1:0] beats;
   } entry_type;

endpackage

FILE: rtl/pcm_credit_pacing_queue.sv
// Credit pacing queue for a PCM ring.
// req channel: req_tuser carries the event kind (consume, frame, drain report,
// rebase); req_tdata carries the byte/beat amount and the reader pointer.
// rsp channel: exactly one item per request, giving credit word, ring free
// beats, the decode-permitted flag, write pointer and frame count after the
// event. csr channel: register 0 drain enable, register 1 needed free beats;
// always ready; the user must write it only while the block is idle, and
// the block itself does not enforce this. Consume, rebase and a frame into a
// free slot pass dispatch and result; a frame merged into a full queue adds a
// merge step; a drain report retiring n entries (n at most QUEUE_DEPTH-1) runs
// a check and step pass per entry, then a flush, ending with the queue empty or
// with an undrained entry that stops the retire loop. The loop reads one queue
// entry per pass through the single port of the queue memory. The result sits
// in an output register, and the next item is accepted while it waits. If the
// receiver stalls, the following result holds in the controller until the
// register frees. Reset clears the queue, pointers and totals; the queue memory
// itself is not cleared, as no entry is read before it is written.
module pcm_credit_pacing_queue #(
   parameter int RING_BEATS  = pcq_pkg::RingBeatsDefault,
   parameter int QUEUE_DEPTH = pcq_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // amount[15:0], read_ptr[31:16]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // credit_word[15:0], ring_free[30:16], decode_ok[31],
                                    // write_ptr[47:32], sync_count[55:48]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [14:0] csr_data
);

   pcq_pkg::cmd_type    cmd;
   pcq_pkg::status_type status;

   assign csr_ready = 1'b1;

   pcq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status_i   (status),
      .cmd_o      (cmd)
   );

   pcq_dp #(
      .RING_BEATS  (RING_BEATS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_i     (cmd),
      .status_o  (status)
   );

endmodule

FILE: rtl/pcq_ctrl.sv
`include "pcm_credit_pacing_queue_macros.svh"

module pcq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  pcq_pkg::status_type status_i,
   output pcq_pkg::cmd_type    cmd_o
);

   pcq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_o.op        = pcq_pkg::OP_NONE;
      cmd_o.load_item = 1'b0;
      cmd_o.load_rsp  = 1'b0;
      req_tready    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         pcq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_o.load_item = 1'b1;
               state_in        = pcq_pkg::ST_DISPATCH;
            end
         end
         pcq_pkg::ST_DISPATCH: begin
            case (status_i.kind)
               pcq_pkg::KIND_CONSUME: begin
                  cmd_o.op = pcq_pkg::OP_CONSUME;
                  state_in = pcq_pkg::ST_RESULT;
               end
               pcq_pkg::KIND_FRAME: begin
                  // full queue: fetch the newest entry and fold into it
                  if (status_i.q_full) begin
                     cmd_o.op = pcq_pkg::OP_RD_LAST;
                     state_in = pcq_pkg::ST_MERGE;
                  end else begin
                     cmd_o.op = pcq_pkg::OP_FRAME_NEW;
                     state_in = pcq_pkg::ST_RESULT;
                  end
               end
               pcq_pkg::KIND_DRAIN: begin
                  cmd_o.op = pcq_pkg::OP_DRAIN_START;
                  state_in = pcq_pkg::ST_CHECK;
               end
               default: begin
                  cmd_o.op = pcq_pkg::OP_REBASE;
                  state_in = pcq_pkg::ST_RESULT;
               end
            endcase
         end
         pcq_pkg::ST_MERGE: begin
            cmd_o.op = pcq_pkg::OP_FRAME_MERGE;
            state_in = pcq_pkg::ST_RESULT;
         end
         pcq_pkg::ST_CHECK: begin
            if (status_i.q_empty) begin
               state_in = pcq_pkg::ST_FLUSH;
            end else begin
               cmd_o.op = pcq_pkg::OP_RD_TAIL;
               state_in = pcq_pkg::ST_STEP;
            end
         end
         pcq_pkg::ST_STEP: begin
            if (status_i.can_retire) begin
               cmd_o.op = pcq_pkg::OP_RETIRE;
               state_in = pcq_pkg::ST_CHECK;
            end else begin
               state_in = pcq_pkg::ST_FLUSH;
            end
         end
         pcq_pkg::ST_FLUSH: begin
            cmd_o.op = pcq_pkg::OP_FLUSH;
            state_in = pcq_pkg::ST_RESULT;
         end
         pcq_pkg::ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd_o.load_rsp = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = pcq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   `PCQ_ASSERT_NEXT(a_load_shows, clock, reset, cmd_o.load_rsp, rsp_tvalid,
      "loaded result not presented")
   `PCQ_ASSERT_NOW(a_retire_legal, clock, reset, cmd_o.op == pcq_pkg::OP_RETIRE,
      status_i.can_retire && !status_i.q_empty, "retire issued on empty or undrained entry")
   `PCQ_ASSERT_NOW(a_merge_full, clock, reset, state_ff == pcq_pkg::ST_MERGE,
      status_i.q_full, "merge entered with queue not full")

endmodule

FILE: rtl/pcq_dp.sv
`include "pcm_credit_pacing_queue_macros.svh"

module pcq_dp #(
   parameter int RING_BEATS  = pcq_pkg::RingBeatsDefault,
   parameter int QUEUE_DEPTH = pcq_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_tuser,
   input  logic [31:0]         req_tdata,
   output logic [55:0]         rsp_tdata,
   input  logic                csr_valid,
   input  logic                csr_index,
   input  logic [14:0]         csr_data,
   input  pcq_pkg::cmd_type    cmd_i,
   output pcq_pkg::status_type status_o
);

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int PW = pcq_pkg::PtrWidth;
   localparam int TW = pcq_pkg::TotWidth;

   pcq_pkg::kind_type  kind_ff;
   logic [PW-1:0]      amount_ff;
   logic [PW-1:0]      ptr_ff;

   logic [PW-1:0] wr_ptr_ff,  wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff,  rd_ptr_in;   // doubles as the last reported pointer
   logic [TW-1:0] drained_ff, drained_in;
   logic [TW-1:0] pending_ff, pending_in;
   logic [TW-1:0] credit_ff,  credit_in;
   logic [QW-1:0] head_ff,    head_in;
   logic [QW-1:0] tail_ff,    tail_in;
   logic [7:0]    sync_ff,    sync_in;

   logic          drain_en_ff;
   logic [14:0]   need_ff;

   pcq_pkg::entry_type queue_mem [QUEUE_DEPTH];
   pcq_pkg::entry_type rd_entry_ff;
   pcq_pkg::entry_type wr_entry;
   logic               mem_we;
   logic               mem_re;
   logic [QW-1:0]      mem_addr;

   logic [55:0]   rsp_data_ff;

   logic [QW-1:0] head_next;
   logic [QW-1:0] head_prev;
   logic [QW-1:0] tail_next;
   logic [PW-1:0] used;
   logic [PW:0]   free_wide;
   logic [14:0]   ring_free;
   logic          decode_ok;

   function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] idx);
      logic [QW-1:0] res;
      if (idx == QW'(QUEUE_DEPTH - 1)) res = '0;
      else                             res = idx + QW'(1);
      return res;
   endfunction

   assign head_next = wrap_inc(head_ff);
   assign tail_next = wrap_inc(tail_ff);
   assign head_prev = (head_ff == '0) ? QW'(QUEUE_DEPTH - 1) : head_ff - QW'(1);

   assign status_o.kind       = kind_ff;
   assign status_o.q_empty    = (head_ff == tail_ff);
   assign status_o.q_full     = (head_next == tail_ff);
   assign status_o.can_retire = (drained_ff >= {{(TW-PW){1'b0}}, rd_entry_ff.beats});

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd_i.load_item) begin
         kind_ff   <= pcq_pkg::kind_type'(req_tuser);
         amount_ff <= req_tdata[15:0];
         ptr_ff    <= req_tdata[31:16];
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_en_ff <= 1'b0;
         need_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            pcq_pkg::CSR_DRAIN_ENABLE: drain_en_ff <= csr_data[0];
            pcq_pkg::CSR_NEED_BEATS:   need_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      drained_in = drained_ff;
      pending_in = pending_ff;
      credit_in  = credit_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      sync_in    = sync_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = tail_ff;
      wr_entry.bytes = pending_ff;
      wr_entry.beats = amount_ff;
      case (cmd_i.op)
         pcq_pkg::OP_CONSUME: begin
            pending_in = pending_ff + {{(TW-PW){1'b0}}, amount_ff};
         end
         pcq_pkg::OP_FRAME_NEW: begin
            mem_we     = 1'b1;
            mem_addr   = head_ff;
            head_in    = head_next;
            wr_ptr_in  = wr_ptr_ff + amount_ff;
            pending_in = '0;
            sync_in    = sync_ff + 8'd1;
         end
         pcq_pkg::OP_RD_LAST: begin
            mem_re   = 1'b1;
            mem_addr = head_prev;
         end
         pcq_pkg::OP_FRAME_MERGE: begin
            mem_we         = 1'b1;
            mem_addr       = head_prev;
            wr_entry.bytes = rd_entry_ff.bytes + pending_ff;
            wr_entry.beats = rd_entry_ff.beats + amount_ff;
            wr_ptr_in      = wr_ptr_ff + amount_ff;
            pending_in     = '0;
            sync_in        = sync_ff + 8'd1;
         end
         pcq_pkg::OP_DRAIN_START: begin
            rd_ptr_in  = ptr_ff;
            drained_in = drained_ff + {{(TW-PW){1'b0}}, PW'(ptr_ff - rd_ptr_ff)};
         end
         pcq_pkg::OP_RD_TAIL: begin
            mem_re = 1'b1;
         end
         pcq_pkg::OP_RETIRE: begin
            drained_in = drained_ff - {{(TW-PW){1'b0}}, rd_entry_ff.beats};
            credit_in  = credit_ff + rd_entry_ff.bytes;
            tail_in    = tail_next;
         end
         pcq_pkg::OP_FLUSH: begin
            // empty queue: release leftover bytes straight away
            if (head_ff == tail_ff && pending_ff != '0) begin
               credit_in  = credit_ff + pending_ff;
               pending_in = '0;
               drained_in = '0;
            end
         end
         pcq_pkg::OP_REBASE: begin
            rd_ptr_in  = ptr_ff;
            head_in    = '0;
            tail_in    = '0;
            pending_in = '0;
            drained_in = '0;
            credit_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         drained_ff <= '0;
         pending_ff <= '0;
         credit_ff  <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         sync_ff    <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         drained_ff <= drained_in;
         pending_ff <= pending_in;
         credit_ff  <= credit_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         sync_ff    <= sync_in;
      end
   end

   // Queue storage, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) queue_mem[mem_addr] <= wr_entry;
      if (mem_re) rd_entry_ff <= queue_mem[mem_addr];
   end

   assign used      = wr_ptr_ff - rd_ptr_ff;
   assign free_wide = (PW+1)'(RING_BEATS) - (PW+1)'(1) - {1'b0, used};
   assign ring_free = ({1'b0, used} >= (PW+1)'(RING_BEATS)) ? '0 : free_wide[14:0];
   assign decode_ok = drain_en_ff && (ring_free >= need_ff);

   always_ff @(posedge clock) begin
      if (cmd_i.load_rsp) begin
         rsp_data_ff <= {sync_ff, wr_ptr_ff, decode_ok, ring_free, credit_ff[15:0]};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   `PCQ_ASSERT_NEXT(a_retire_moves_tail, clock, reset, cmd_i.op == pcq_pkg::OP_RETIRE,
      tail_ff != $past(tail_ff), "retire did not advance the tail")
   `PCQ_ASSERT_NEXT(a_frame_counts, clock, reset,
      cmd_i.op == pcq_pkg::OP_FRAME_NEW || cmd_i.op == pcq_pkg::OP_FRAME_MERGE,
      sync_ff == 8'($past(sync_ff) + 8'd1) && pending_ff == '0,
      "frame did not count or clear pending bytes")
   `PCQ_ASSERT_NEXT(a_rebase_clears, clock, reset, cmd_i.op == pcq_pkg::OP_REBASE,
      head_ff == tail_ff && credit_ff == '0, "rebase left queue or credit")

endmodule
